// ===== hdl/tcab_pkg.sv =====
package tcab_pkg;

    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int CNT_W     = 10;
    localparam int TOTAL_W   = 14;
    localparam int LIMIT_W   = 5;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_SAT = 16383;
    localparam int LIMIT_RESET = 8;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_UP      = 3'd2,
        OP_DOWN    = 3'd3,
        OP_BALANCE = 3'd4,
        OP_LEAF    = 3'd5,
        OP_QUERY   = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_TARGET = 2'd1,
        ST_NONE   = 2'd2,
        ST_MISS   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== hdl/tcab_req_if.sv =====
interface tcab_req_if
    import tcab_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [ADDR_W-1:0] child_addr;
    logic [PORT_W-1:0] child_port;

    modport source (output valid, req_type, child_addr, child_port, input ready);
    modport sink   (input valid, req_type, child_addr, child_port, output ready);
endinterface

// ===== hdl/tcab_rsp_if.sv =====
interface tcab_rsp_if
    import tcab_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   target_addr;
    logic [CNT_W-1:0]    child_count;
    logic [TOTAL_W-1:0]  total_successors;
    logic [LIMIT_W-1:0]  free_capacity;

    modport source (output valid, status, target_addr, child_count, total_successors,
                    free_capacity, input ready);
    modport sink   (input valid, status, target_addr, child_count, total_successors,
                    free_capacity, output ready);
endinterface

// ===== hdl/tcab_ctrl.sv =====
module tcab_ctrl
    import tcab_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (dp_status.walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!dp_status.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            S_WALK:
            begin
                cmd.step = !dp_status.walk_done;
            end
            S_FINISH:
            begin
                cmd.finish = !dp_status.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/tcab_datapath.sv =====
module tcab_datapath
    import tcab_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int COUNT_MAX   = 999
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          dp_status,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic [2:0]          in_req_type,
    input  logic [ADDR_W-1:0]   in_child_addr,
    input  logic [PORT_W-1:0]   in_child_port,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] out_status,
    output logic [ADDR_W-1:0]   out_target_addr,
    output logic [CNT_W-1:0]    out_child_count,
    output logic [TOTAL_W-1:0]  out_total_successors,
    output logic [LIMIT_W-1:0]  out_free_capacity
);

    localparam int IW  = $clog2(TABLE_DEPTH + 1);
    localparam int IXW = $clog2(TABLE_DEPTH);
    localparam int SW  = $clog2(TABLE_DEPTH * (COUNT_MAX + 1) + 1);
    localparam int LIM_RST = (LIMIT_RESET > TABLE_DEPTH) ? TABLE_DEPTH : LIMIT_RESET;

    logic [ADDR_W-1:0] addr_tab_reg [TABLE_DEPTH];
    logic [PORT_W-1:0] port_tab_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]  cnt_tab_reg  [TABLE_DEPTH];

    logic [IW-1:0]     count_reg;
    logic [IW-1:0]     cap_reg;
    logic [IW-1:0]     limit_reg;

    op_t               op_reg;
    logic [ADDR_W-1:0] addr_q_reg;
    logic [PORT_W-1:0] port_q_reg;
    logic [IW-1:0]     i_reg;
    logic [IW-1:0]     j_reg;
    logic [IW-1:0]     hits_reg;
    logic [SW-1:0]     sum_reg;
    logic              found_reg;
    logic              down_ok_reg;
    logic [CNT_W-1:0]  qcnt_reg;
    logic [CNT_W-1:0]  min_c_reg;
    logic [ADDR_W-1:0] min_a_reg;
    logic [CNT_W-1:0]  max_c_reg;
    logic [ADDR_W-1:0] max_a_reg;

    logic              out_valid_reg;

    logic [ADDR_W-1:0] e_addr;
    logic [PORT_W-1:0] e_port;
    logic [CNT_W-1:0]  e_cnt;
    logic              match;
    logic              drop;
    logic              first;
    logic [CNT_W-1:0]  new_cnt;

    logic              add_ok;
    status_t           fin_status;
    logic [ADDR_W-1:0] fin_target;
    logic [CNT_W-1:0]  fin_qcnt;
    logic [IW-1:0]     count_next;
    logic [IW-1:0]     cap_next;
    logic [IW:0]       cap_sum;
    logic [SW:0]       tot;
    logic [TOTAL_W-1:0] tot_sat;
    logic [IW-1:0]     lim_clamped;
    logic              bal_move;

    assign e_addr = addr_tab_reg[i_reg[IXW-1:0]];
    assign e_port = port_tab_reg[i_reg[IXW-1:0]];
    assign e_cnt  = cnt_tab_reg[i_reg[IXW-1:0]];
    assign match  = (e_addr == addr_q_reg);
    assign drop   = (op_reg == OP_REMOVE) && match;
    assign first  = match && !found_reg;

    always_comb
    begin
        new_cnt = e_cnt;
        if (op_reg == OP_UP && match && e_cnt < CNT_W'(COUNT_MAX))
        begin
            new_cnt = e_cnt + CNT_W'(1);
        end
        else if (op_reg == OP_DOWN && first && e_cnt != '0)
        begin
            new_cnt = e_cnt - CNT_W'(1);
        end
    end

    assign dp_status.walk_done = (i_reg == count_reg);
    assign dp_status.out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            lim_clamped = IW'(1);
        end
        else if (32'(cfg_wr_data) > TABLE_DEPTH)
        begin
            lim_clamped = IW'(TABLE_DEPTH);
        end
        else
        begin
            lim_clamped = IW'(cfg_wr_data);
        end
    end

    assign add_ok   = (cap_reg != '0) && (32'(count_reg) < TABLE_DEPTH);
    assign cap_sum  = {1'b0, cap_reg} + {1'b0, hits_reg};
    assign bal_move = ((cap_reg != '0) && (max_c_reg != '0))
                   || ({1'b0, max_c_reg} > ({1'b0, min_c_reg} + (CNT_W + 1)'(1)));

    always_comb
    begin
        fin_status = ST_NONE;
        fin_target = '0;
        fin_qcnt   = '0;
        count_next = count_reg;
        cap_next   = cap_reg;
        unique case (op_reg)
            OP_ADD:
            begin
                if (add_ok)
                begin
                    fin_status = ST_DONE;
                    count_next = count_reg + IW'(1);
                    cap_next   = cap_reg - IW'(1);
                end
                else if (count_reg != '0)
                begin
                    fin_status = ST_TARGET;
                    fin_target = min_a_reg;
                end
            end
            OP_REMOVE:
            begin
                fin_status = (hits_reg != '0) ? ST_DONE : ST_MISS;
                count_next = j_reg;
                cap_next   = (cap_sum > {1'b0, limit_reg}) ? limit_reg : cap_sum[IW-1:0];
            end
            OP_UP:
            begin
                fin_status = found_reg ? ST_DONE : ST_MISS;
            end
            OP_DOWN:
            begin
                fin_status = (found_reg && down_ok_reg) ? ST_DONE : ST_MISS;
            end
            OP_BALANCE:
            begin
                if (cap_reg < limit_reg && count_reg != '0 && bal_move)
                begin
                    fin_status = ST_TARGET;
                    fin_target = max_a_reg;
                end
            end
            OP_LEAF:
            begin
                if (count_reg != '0)
                begin
                    fin_status = ST_TARGET;
                    fin_target = max_a_reg;
                end
            end
            OP_QUERY:
            begin
                fin_status = found_reg ? ST_DONE : ST_MISS;
                fin_qcnt   = found_reg ? qcnt_reg : '0;
            end
            default:
            begin
                fin_status = ST_NONE;
            end
        endcase
    end

    assign tot     = (SW + 1)'(count_next) + {1'b0, sum_reg};
    assign tot_sat = (32'(tot) > TOTAL_SAT) ? TOTAL_W'(TOTAL_SAT) : TOTAL_W'(tot);

    // table storage, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.step && !drop)
        begin
            addr_tab_reg[j_reg[IXW-1:0]] <= e_addr;
            port_tab_reg[j_reg[IXW-1:0]] <= e_port;
            cnt_tab_reg[j_reg[IXW-1:0]]  <= new_cnt;
        end
        else if (cmd.finish && op_reg == OP_ADD && add_ok)
        begin
            addr_tab_reg[count_reg[IXW-1:0]] <= addr_q_reg;
            port_tab_reg[count_reg[IXW-1:0]] <= port_q_reg;
            cnt_tab_reg[count_reg[IXW-1:0]]  <= '0;
        end
    end

    // walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg      <= op_t'(in_req_type);
            addr_q_reg  <= in_child_addr;
            port_q_reg  <= in_child_port;
            sum_reg     <= '0;
            found_reg   <= 1'b0;
            down_ok_reg <= 1'b0;
            qcnt_reg    <= '0;
            min_c_reg   <= '1;
            min_a_reg   <= '0;
            max_c_reg   <= '0;
            max_a_reg   <= '0;
        end
        else if (cmd.step)
        begin
            if (!drop)
            begin
                sum_reg <= sum_reg + SW'(new_cnt);
            end
            if (first)
            begin
                found_reg   <= 1'b1;
                qcnt_reg    <= e_cnt;
                down_ok_reg <= (e_cnt != '0);
            end
            if (e_cnt < min_c_reg)
            begin
                min_c_reg <= e_cnt;
                min_a_reg <= e_addr;
            end
            if (e_cnt >= max_c_reg)
            begin
                max_c_reg <= e_cnt;
                max_a_reg <= e_addr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= IW'(LIM_RST);
            limit_reg     <= IW'(LIM_RST);
            i_reg         <= '0;
            j_reg         <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= lim_clamped;
                cap_reg   <= lim_clamped;
                count_reg <= '0;
            end
            else if (cmd.finish)
            begin
                count_reg <= count_next;
                cap_reg   <= cap_next;
            end
            if (cmd.start)
            begin
                i_reg    <= '0;
                j_reg    <= '0;
                hits_reg <= '0;
            end
            else if (cmd.step)
            begin
                i_reg <= i_reg + IW'(1);
                if (drop)
                begin
                    hits_reg <= hits_reg + IW'(1);
                end
                else
                begin
                    j_reg <= j_reg + IW'(1);
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status           <= fin_status;
            out_target_addr      <= fin_target;
            out_child_count      <= fin_qcnt;
            out_total_successors <= tot_sat;
            out_free_capacity    <= LIMIT_W'(cap_next);
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/tree_child_admission_balancer.sv =====
// Child table of a streaming-tree node with admission, removal, count
// tracking, balancing, leaf selection and queries. From acceptance to result
// an item passes through these steps: one to latch the request, one per valid
// entry as the walk reads the table through its single read port, and one to
// settle status, totals and capacity once the output register is free. One
// item is worked at a time; the next is taken as soon as the result sits in
// the output register. A write to the upload limit clears the table at once
// and sets the free capacity to the clamped limit.
module tree_child_admission_balancer
    import tcab_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int COUNT_MAX   = 999
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    tcab_req_if.sink           req,
    tcab_rsp_if.source         rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    tcab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    tcab_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_MAX   (COUNT_MAX)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .dp_status            (dp_status),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .in_req_type          (req.req_type),
        .in_child_addr        (req.child_addr),
        .in_child_port        (req.child_port),
        .out_ready            (rsp.ready),
        .out_valid            (rsp.valid),
        .out_status           (rsp.status),
        .out_target_addr      (rsp.target_addr),
        .out_child_count      (rsp.child_count),
        .out_total_successors (rsp.total_successors),
        .out_free_capacity    (rsp.free_capacity)
    );

endmodule
